FILE: rtl/fsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_pkg
// Shared types, codes and letter/cell helpers for the four-square cipher.
// ----------------------------------------------------------------------------
package fsq_pkg;

  // letter and square geometry
  localparam int LETTERS = 26;
  localparam int CELLS_N = 25;
  localparam logic [4:0] CELLS       = 5'd25;
  localparam logic [4:0] LETTER_I    = 5'd8;
  localparam logic [4:0] LETTER_J    = 5'd9;
  localparam logic [4:0] LAST_LETTER = 5'd25;

  // command codes on the request port
  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_KEY1    = 3'd1;
  localparam logic [2:0] CMD_KEY2    = 3'd2;
  localparam logic [2:0] CMD_FINAL   = 3'd3;
  localparam logic [2:0] CMD_ENCRYPT = 3'd4;
  localparam logic [2:0] CMD_DECRYPT = 3'd5;

  // classified operation codes between front and back
  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_KEY1  = 3'd1;
  localparam logic [2:0] OP_KEY2  = 3'd2;
  localparam logic [2:0] OP_FIN   = 3'd3;
  localparam logic [2:0] OP_ENC   = 3'd4;
  localparam logic [2:0] OP_DEC   = 3'd5;
  localparam logic [2:0] OP_NOP   = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_PHASE  = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [2:0] command;
    logic [4:0] first_letter;
    logic [4:0] second_letter;
  } in_item_t;

  typedef struct packed {
    logic [4:0] first_out;
    logic [4:0] second_out;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] letter_a;
    logic [4:0] letter_b;
    logic       range_bad;
  } task_t;

  // seen mask for one key letter, I and J mark each other
  function automatic logic [25:0] letter_mask(input logic [4:0] c);
    logic [25:0] m;
    m = 26'd1 << c;
    if (c == LETTER_I || c == LETTER_J) begin
      m[LETTER_I] = 1'b1;
      m[LETTER_J] = 1'b1;
    end
    return m;
  endfunction

  // plain square cell of a letter, J folds onto I
  function automatic logic [4:0] plain_cell(input logic [4:0] c);
    return (c >= LETTER_J) ? c - 5'd1 : c;
  endfunction

  // letter of a plain square cell
  function automatic logic [4:0] plain_letter(input logic [4:0] slot);
    return (slot >= LETTER_J) ? slot + 5'd1 : slot;
  endfunction

  function automatic logic [2:0] cell_row(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20)      r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  function automatic logic [4:0] cell_index(input logic [2:0] r, input logic [2:0] c);
    return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
  endfunction

  function automatic logic [2:0] cell_col(input logic [4:0] p);
    logic [4:0] d;
    d = p - cell_index(cell_row(p), 3'd0);
    return d[2:0];
  endfunction

endpackage

FILE: rtl/four_square_cipher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_square_cipher_top
// Four-square cipher engine with key loading, finalize and pair lookup.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken at a clock edge where start is high and
//   busy is low; request carries the command and up to two letters.
//   Every transaction yields exactly one result: done pulses for one cycle
//   with result valid in that cycle. The receiver cannot stall, so results
//   are never held back.
//   An accepted command passes through the holding stage and the queue to
//   the back-end sequencer. An encrypt or decrypt pair does a registered
//   read of the square or position tables, then the output compute, and
//   finalize walks the 26 letters one per cycle.
//   The back end works on one task at a time. A holding stage and a
//   two-entry queue let new commands be taken while the back end works;
//   busy rises only when both are full.
//   Reset clears the key state and the finalized flag; square contents are
//   undefined until keys are loaded and finalized.
// ----------------------------------------------------------------------------
module four_square_cipher_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  fsq_pkg::in_item_t  request,
  output logic               busy,
  output logic               done,
  output fsq_pkg::out_item_t result
);
  import fsq_pkg::*;

  logic  push;
  task_t push_task;
  logic  q_full;
  logic  q_empty;
  logic  pop;
  task_t head;

  fsq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .push_task (push_task)
  );

  fsq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_task (push_task),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  fsq_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .done    (done),
    .result  (result)
  );

endmodule

FILE: rtl/fsq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_front
// Takes command transactions, decodes them and range-checks the letters,
// then hands the classified task to the queue.
// ----------------------------------------------------------------------------
module fsq_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  fsq_pkg::in_item_t request,
  input  logic             q_full,
  output logic             busy,
  output logic             push,
  output fsq_pkg::task_t   push_task
);
  import fsq_pkg::*;

  logic  front_valid;
  task_t held;
  task_t classified;
  logic  accept;

  assign busy      = front_valid & q_full;
  assign push      = front_valid & ~q_full;
  assign accept    = start & ~busy;
  assign push_task = held;

  // command decode and letter range check
  always_comb begin
    classified.letter_a  = request.first_letter;
    classified.letter_b  = request.second_letter;
    classified.range_bad = 1'b0;
    unique case (request.command)
      CMD_CLEAR: classified.op = OP_CLEAR;
      CMD_KEY1: begin
        classified.op        = OP_KEY1;
        classified.range_bad = request.first_letter > LAST_LETTER;
      end
      CMD_KEY2: begin
        classified.op        = OP_KEY2;
        classified.range_bad = request.first_letter > LAST_LETTER;
      end
      CMD_FINAL: classified.op = OP_FIN;
      CMD_ENCRYPT: begin
        classified.op        = OP_ENC;
        classified.range_bad = (request.first_letter > LAST_LETTER) ||
                               (request.second_letter > LAST_LETTER);
      end
      CMD_DECRYPT: begin
        classified.op        = OP_DEC;
        classified.range_bad = (request.first_letter > LAST_LETTER) ||
                               (request.second_letter > LAST_LETTER);
      end
      default: classified.op = OP_NOP;
    endcase
  end

  // holding stage
  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= 1'b1;
    end else if (push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= classified;
    end
  end

endmodule

FILE: rtl/fsq_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_queue
// Short first-in first-out queue of classified tasks between front and back.
// ----------------------------------------------------------------------------
module fsq_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fsq_pkg::task_t push_task,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output fsq_pkg::task_t head
);
  import fsq_pkg::*;

  task_t              slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;
  logic               do_push;
  logic               do_pop;

  assign full    = count == QDEPTH[QPTR_W:0];
  assign empty   = count == '0;
  assign head    = slots[rd_ptr];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // task storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_task;
    end
  end

endmodule

FILE: rtl/fsq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_back
// Executes tasks: key placement, the finalize fill walk and pair lookups
// through the keyed squares and their position tables.
// ----------------------------------------------------------------------------
module fsq_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  fsq_pkg::task_t     head,
  output logic               pop,
  output logic               done,
  output fsq_pkg::out_item_t result
);
  import fsq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FILL = 2'd1;
  localparam logic [1:0] S_LOOK = 2'd2;

  // square storage and letter-to-cell tables
  logic [4:0] sq1  [CELLS_N];
  logic [4:0] sq2  [CELLS_N];
  logic [4:0] pos1 [LETTERS];
  logic [4:0] pos2 [LETTERS];
  logic [4:0] rd_sq1, rd_sq2, rd_pos1, rd_pos2;

  logic [1:0]  state, state_next;
  logic [4:0]  fill_letter, fill_letter_next;
  logic [25:0] seen1, seen1_next, seen2, seen2_next;
  logic [4:0]  cnt1, cnt1_next, cnt2, cnt2_next;
  logic        jin1, jin1_next, jin2, jin2_next;
  logic        ready, ready_next;
  task_t       cur, cur_next;

  logic        emit;
  out_item_t   emit_item;
  logic        we1, we2;
  logic [4:0]  wd1, wd2;
  logic        issue;
  logic [4:0]  pa, pb, enc_addr1, enc_addr2;
  logic        abs1, abs2;

  // encrypt addresses from the plain cells of the head task
  assign pa        = plain_cell(head.letter_a);
  assign pb        = plain_cell(head.letter_b);
  assign enc_addr1 = cell_index(cell_row(pa), cell_col(pb));
  assign enc_addr2 = cell_index(cell_row(pb), cell_col(pa));

  // the one of I and J missing from each square has no table entry
  assign abs1 = (cur.letter_a == LETTER_J && !jin1) || (cur.letter_a == LETTER_I && jin1);
  assign abs2 = (cur.letter_b == LETTER_J && !jin2) || (cur.letter_b == LETTER_I && jin2);

  // sequencer
  always_comb begin
    state_next       = state;
    fill_letter_next = fill_letter;
    seen1_next       = seen1;
    seen2_next       = seen2;
    cnt1_next        = cnt1;
    cnt2_next        = cnt2;
    jin1_next        = jin1;
    jin2_next        = jin2;
    ready_next       = ready;
    cur_next         = cur;
    pop              = 1'b0;
    emit             = 1'b0;
    emit_item        = '0;
    we1              = 1'b0;
    we2              = 1'b0;
    wd1              = head.letter_a;
    wd2              = head.letter_a;
    issue            = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          unique case (head.op) inside
            OP_CLEAR: begin
              seen1_next = '0;
              seen2_next = '0;
              cnt1_next  = '0;
              cnt2_next  = '0;
              jin1_next  = 1'b0;
              jin2_next  = 1'b0;
              ready_next = 1'b0;
              emit       = 1'b1;
            end
            OP_KEY1: begin
              emit = 1'b1;
              if (ready) begin
                emit_item.status = ST_PHASE;
              end else if (head.range_bad) begin
                emit_item.status = ST_ABSENT;
              end else if (!seen1[head.letter_a]) begin
                seen1_next = seen1 | letter_mask(head.letter_a);
                jin1_next  = jin1 | (head.letter_a == LETTER_J);
                if (cnt1 < CELLS) begin
                  we1       = 1'b1;
                  cnt1_next = cnt1 + 5'd1;
                end
              end
            end
            OP_KEY2: begin
              emit = 1'b1;
              if (ready) begin
                emit_item.status = ST_PHASE;
              end else if (head.range_bad) begin
                emit_item.status = ST_ABSENT;
              end else if (!seen2[head.letter_a]) begin
                seen2_next = seen2 | letter_mask(head.letter_a);
                jin2_next  = jin2 | (head.letter_a == LETTER_J);
                if (cnt2 < CELLS) begin
                  we2       = 1'b1;
                  cnt2_next = cnt2 + 5'd1;
                end
              end
            end
            OP_FIN: begin
              if (ready) begin
                emit             = 1'b1;
                emit_item.status = ST_PHASE;
              end else begin
                if (!seen1[LETTER_I] && !seen1[LETTER_J]) begin
                  seen1_next[LETTER_J] = 1'b1;
                end
                if (!seen2[LETTER_I] && !seen2[LETTER_J]) begin
                  seen2_next[LETTER_J] = 1'b1;
                end
                fill_letter_next = '0;
                state_next       = S_FILL;
              end
            end
            OP_ENC, OP_DEC: begin
              if (!ready) begin
                emit             = 1'b1;
                emit_item.status = ST_PHASE;
              end else if (head.range_bad) begin
                emit             = 1'b1;
                emit_item.status = ST_ABSENT;
              end else begin
                cur_next   = head;
                issue      = 1'b1;
                state_next = S_LOOK;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_FILL: begin
        // append each unseen letter in alphabet order
        wd1 = fill_letter;
        wd2 = fill_letter;
        if (!seen1[fill_letter] && cnt1 < CELLS) begin
          we1       = 1'b1;
          cnt1_next = cnt1 + 5'd1;
        end
        if (!seen2[fill_letter] && cnt2 < CELLS) begin
          we2       = 1'b1;
          cnt2_next = cnt2 + 5'd1;
        end
        if (fill_letter == LAST_LETTER) begin
          ready_next = 1'b1;
          emit       = 1'b1;
          state_next = S_IDLE;
        end else begin
          fill_letter_next = fill_letter + 5'd1;
        end
      end
      S_LOOK: begin
        emit       = 1'b1;
        state_next = S_IDLE;
        if (cur.op == OP_ENC) begin
          emit_item.first_out  = rd_sq1;
          emit_item.second_out = rd_sq2;
        end else if (abs1 || abs2) begin
          emit_item.status = ST_ABSENT;
        end else begin
          emit_item.first_out  =
            plain_letter(cell_index(cell_row(rd_pos1), cell_col(rd_pos2)));
          emit_item.second_out =
            plain_letter(cell_index(cell_row(rd_pos2), cell_col(rd_pos1)));
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fill_letter <= '0;
      seen1       <= '0;
      seen2       <= '0;
      cnt1        <= '0;
      cnt2        <= '0;
      jin1        <= 1'b0;
      jin2        <= 1'b0;
      ready       <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      fill_letter <= fill_letter_next;
      seen1       <= seen1_next;
      seen2       <= seen2_next;
      cnt1        <= cnt1_next;
      cnt2        <= cnt2_next;
      jin1        <= jin1_next;
      jin2        <= jin2_next;
      ready       <= ready_next;
      done        <= emit;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (emit) begin
      result <= emit_item;
    end
  end

  // square and position table writes, registered lookups
  always_ff @(posedge clk) begin
    if (we1) begin
      sq1[cnt1] <= wd1;
      pos1[wd1] <= cnt1;
    end
    if (we2) begin
      sq2[cnt2] <= wd2;
      pos2[wd2] <= cnt2;
    end
    if (issue) begin
      rd_sq1  <= sq1[enc_addr1];
      rd_sq2  <= sq2[enc_addr2];
      rd_pos1 <= pos1[head.letter_a];
      rd_pos2 <= pos2[head.letter_b];
    end
  end

endmodule

FILE: bench/tb_four_square_cipher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_square_cipher_top
// Self-checking bench for the four-square cipher engine. A tracker keeps its
// own copy of both keyed squares, the seen masks and the letter-to-cell
// tables. It predicts the output of every accepted command transaction and
// compares each done pulse, in order, against that prediction. Stimulus is a
// directed pass over the phase and range corner cases, then random key
// sessions (clear, key streams, finalize, pair traffic) mixed with noise.
// ----------------------------------------------------------------------------
module tb_four_square_cipher_top;
  import fsq_pkg::*;

  // command codes the block treats as no-ops
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  // letter-to-cell entry with no cell
  localparam logic [5:0] NO_CELL = 6'd63;
  localparam int SIDE = 5;
  localparam int ITEM_TARGET = 450;
  localparam int CYCLE_LIMIT = 200000;

  // tracks key state and the outputs still owed by the block
  class four_square_tracker;
    logic [4:0]  key_square [2][25];
    logic [25:0] seen [2];
    logic [4:0]  fill [2];
    logic [5:0]  cell_of [2][26];
    bit          ready;
    out_item_t   outputs_due [$];
    int          errors;

    function new();
      errors = 0;
      clear_keys();
    endfunction

    function void clear_keys();
      for (int s = 0; s < 2; s++) begin
        seen[s] = '0;
        fill[s] = '0;
        for (int c = 0; c < LETTERS; c++) cell_of[s][c] = NO_CELL;
      end
      ready = 1'b0;
    endfunction

    // place one key letter, I and J shadow each other
    function void place_key(int s, logic [4:0] c);
      if (seen[s][c]) return;
      seen[s][c] = 1'b1;
      if (c == LETTER_I) seen[s][LETTER_J] = 1'b1;
      else if (c == LETTER_J) seen[s][LETTER_I] = 1'b1;
      if (fill[s] < CELLS) begin
        key_square[s][fill[s]] = c;
        fill[s] = fill[s] + 5'd1;
      end
    endfunction

    // fill the rest of a square in alphabet order and index it
    function void complete_square(int s);
      if (!seen[s][LETTER_I] && !seen[s][LETTER_J]) seen[s][LETTER_J] = 1'b1;
      for (int c = 0; c < LETTERS; c++) begin
        if (!seen[s][c] && fill[s] < CELLS) begin
          key_square[s][fill[s]] = 5'(c);
          fill[s] = fill[s] + 5'd1;
        end
      end
      for (int c = 0; c < LETTERS; c++) cell_of[s][c] = NO_CELL;
      for (int k = 0; k < fill[s] && k < CELLS_N; k++) cell_of[s][key_square[s][k]] = 6'(k);
    endfunction

    // output of the block for one command, updating the key state
    function out_item_t cipher_step(in_item_t it);
      out_item_t o;
      int p1, p2, r1, c1, r2, c2;
      o = '0;
      o.status = ST_OK;
      case (it.command) inside
        CMD_CLEAR: clear_keys();
        CMD_KEY1, CMD_KEY2: begin
          if (ready) o.status = ST_PHASE;
          else if (it.first_letter > LAST_LETTER) o.status = ST_ABSENT;
          else place_key((it.command == CMD_KEY1) ? 0 : 1, it.first_letter);
        end
        CMD_FINAL: begin
          if (ready) begin
            o.status = ST_PHASE;
          end else begin
            complete_square(0);
            complete_square(1);
            ready = 1'b1;
          end
        end
        CMD_ENCRYPT: begin
          if (!ready) begin
            o.status = ST_PHASE;
          end else if (it.first_letter > LAST_LETTER || it.second_letter > LAST_LETTER) begin
            o.status = ST_ABSENT;
          end else begin
            // plain squares skip J, so J lands on the cell of I
            p1 = (it.first_letter >= LETTER_J) ? it.first_letter - 1 : it.first_letter;
            p2 = (it.second_letter >= LETTER_J) ? it.second_letter - 1 : it.second_letter;
            r1 = p1 / SIDE; c1 = p1 % SIDE;
            r2 = p2 / SIDE; c2 = p2 % SIDE;
            o.first_out  = key_square[0][r1 * SIDE + c2];
            o.second_out = key_square[1][r2 * SIDE + c1];
          end
        end
        CMD_DECRYPT: begin
          if (!ready) begin
            o.status = ST_PHASE;
          end else if (it.first_letter > LAST_LETTER || it.second_letter > LAST_LETTER) begin
            o.status = ST_ABSENT;
          end else if (cell_of[0][it.first_letter] >= CELLS_N ||
                       cell_of[1][it.second_letter] >= CELLS_N) begin
            o.status = ST_ABSENT;
          end else begin
            p1 = cell_of[0][it.first_letter];
            p2 = cell_of[1][it.second_letter];
            r1 = p1 / SIDE; c1 = p1 % SIDE;
            r2 = p2 / SIDE; c2 = p2 % SIDE;
            p1 = r1 * SIDE + c2;
            p2 = r2 * SIDE + c1;
            o.first_out  = 5'((p1 >= LETTER_J) ? p1 + 1 : p1);
            o.second_out = 5'((p2 >= LETTER_J) ? p2 + 1 : p2);
          end
        end
        default: ;
      endcase
      return o;
    endfunction

    function void take_command(in_item_t it);
      outputs_due.push_back(cipher_step(it));
    endfunction

    function void match_output(out_item_t got);
      out_item_t want;
      if (outputs_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result first=%0d second=%0d status=%0d",
                 $time, got.first_out, got.second_out, got.status);
        return;
      end
      want = outputs_due.pop_front();
      if (got.first_out !== want.first_out || got.second_out !== want.second_out ||
          got.status !== want.status) begin
        errors++;
        $display("%0t: mismatch expected %0d %0d %0d, got %0d %0d %0d",
                 $time, want.first_out, want.second_out, want.status,
                 got.first_out, got.second_out, got.status);
      end
    endfunction

    function int outstanding();
      return outputs_due.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      start;
  in_item_t  request;
  logic      busy;
  logic      done;
  out_item_t result;

  four_square_tracker tracker = new();
  int  sent;
  int  cycles;
  bit  idle_on;

  four_square_cipher_top DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // every done pulse is one result transaction
  always @(posedge clk) begin
    if (!rst && done) tracker.match_output(result);
  end

  function automatic in_item_t make_item(logic [2:0] cmd, logic [4:0] a, logic [4:0] b);
    in_item_t it;
    it.command       = cmd;
    it.first_letter  = a;
    it.second_letter = b;
    return it;
  endfunction

  // mostly a real letter, now and then an out-of-range code
  function automatic logic [4:0] pick_letter();
    if ($urandom_range(0, 15) == 0) return 5'($urandom_range(26, 31));
    return 5'($urandom_range(0, 25));
  endfunction

  // hold start until the transaction is taken, then maybe idle a while
  task automatic issue(input in_item_t item);
    start   <= 1'b1;
    request <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.take_command(item);
    sent++;
    // each cycle idles with a 37 percent chance
    while (idle_on && $urandom_range(0, 99) < 37) begin
      start   <= 1'b0;
      request <= in_item_t'($urandom);
      @(posedge clk);
    end
  endtask

  // stream one key square, either a random run or a whole shuffled alphabet
  task automatic load_keys(input logic [2:0] cmd);
    logic [4:0] order [26];
    logic [4:0] t;
    int j;
    int n;
    if ($urandom_range(0, 5) == 0) begin
      for (int i = 0; i < LETTERS; i++) order[i] = 5'(i);
      for (int i = LETTERS - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order[i]; order[i] = order[j]; order[j] = t;
      end
      for (int i = 0; i < LETTERS; i++) issue(make_item(cmd, order[i], 5'($urandom)));
    end else begin
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) issue(make_item(cmd, pick_letter(), 5'($urandom)));
    end
  endtask

  // clear (most of the time), key both squares, finalize, then pair traffic
  task automatic run_session();
    int pairs;
    if ($urandom_range(0, 9) != 0) issue(make_item(CMD_CLEAR, 5'($urandom), 5'($urandom)));
    load_keys(CMD_KEY1);
    load_keys(CMD_KEY2);
    issue(make_item(CMD_FINAL, 5'($urandom), 5'($urandom)));
    pairs = $urandom_range(4, 24);
    for (int i = 0; i < pairs; i++) begin
      issue(make_item($urandom_range(0, 1) ? CMD_ENCRYPT : CMD_DECRYPT,
                      pick_letter(), pick_letter()));
    end
  endtask

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    sent    = 0;
    idle_on = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: phase errors, range errors, I/J exclusion, spare codes
    issue(make_item(CMD_ENCRYPT, 5'd0, 5'd25));
    issue(make_item(CMD_DECRYPT, 5'd25, 5'd0));
    issue(make_item(CMD_KEY1, 5'd31, 5'd31));
    issue(make_item(CMD_KEY1, LETTER_J, 5'd0));
    issue(make_item(CMD_KEY1, LETTER_I, 5'd0));
    issue(make_item(CMD_KEY1, 5'd0, 5'd0));
    issue(make_item(CMD_KEY1, 5'd0, 5'd0));
    issue(make_item(CMD_KEY1, 5'd25, 5'd0));
    issue(make_item(CMD_KEY2, 5'd26, 5'd0));
    issue(make_item(CMD_KEY2, 5'd25, 5'd0));
    issue(make_item(CMD_KEY2, 5'd0, 5'd0));
    issue(make_item(CMD_SPARE_LO, 5'd31, 5'd31));
    issue(make_item(CMD_SPARE_HI, 5'd31, 5'd31));
    issue(make_item(CMD_FINAL, 5'd0, 5'd0));
    issue(make_item(CMD_FINAL, 5'd0, 5'd0));
    issue(make_item(CMD_KEY2, 5'd3, 5'd0));
    issue(make_item(CMD_ENCRYPT, 5'd0, 5'd25));
    issue(make_item(CMD_ENCRYPT, LETTER_J, LETTER_I));
    issue(make_item(CMD_ENCRYPT, 5'd31, 5'd0));
    issue(make_item(CMD_ENCRYPT, 5'd0, 5'd26));
    issue(make_item(CMD_DECRYPT, LETTER_J, 5'd25));
    issue(make_item(CMD_DECRYPT, LETTER_I, 5'd25));
    issue(make_item(CMD_DECRYPT, 5'd0, LETTER_J));
    issue(make_item(CMD_DECRYPT, 5'd0, 5'd31));
    issue(make_item(CMD_CLEAR, 5'd0, 5'd0));
    issue(make_item(CMD_ENCRYPT, 5'd1, 5'd2));

    // random sessions with some noise, one stretch without idling
    while (sent < ITEM_TARGET) begin
      idle_on = !(sent >= 200 && sent < 300);
      if ($urandom_range(0, 4) != 0) begin
        run_session();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          issue(make_item(3'($urandom), 5'($urandom), 5'($urandom)));
        end
      end
    end
    start <= 1'b0;

    // drain, then watch for stray pulses
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
